/* hw/rtl/bsdp_pkg.sv */
`default_nettype none

package bsdp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] PRESCALE_RST   = 16'd999;
    localparam logic [7:0]  PERIOD_TOP_RST = 8'd120;
    localparam logic [7:0]  DUTY_STEP_RST  = 8'd6;
    localparam logic [7:0]  DUTY_MIN_RST   = 8'd36;
    localparam logic [7:0]  DUTY_MAX_RST   = 8'd114;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESCALE   = 3'd0,
        REG_PERIOD_TOP = 3'd1,
        REG_DUTY_STEP  = 3'd2,
        REG_DUTY_MIN   = 3'd3,
        REG_DUTY_MAX   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] prescale;
        logic [7:0]  period_top;
        logic [7:0]  duty_step;
        logic [7:0]  duty_min;
        logic [7:0]  duty_max;
    } cfg_t;

    typedef struct packed {
        logic [7:0] period_next;
        logic       wrap;
    } tb_t;

endpackage

`default_nettype wire

/* hw/rtl/bsdp_if.sv */
`default_nettype none

interface bsdp_cfg_if
    import bsdp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface bsdp_btn_if;
    logic valid;
    logic ready;
    logic btn_a_up;
    logic btn_a_down;
    logic btn_b_up;
    logic btn_b_down;

    modport source (output valid, output btn_a_up, output btn_a_down,
                    output btn_b_up, output btn_b_down, input ready);
    modport sink   (input valid, input btn_a_up, input btn_a_down,
                    input btn_b_up, input btn_b_down, output ready);
endinterface

interface bsdp_res_if;
    logic       valid;
    logic       ready;
    logic       pwm_a;
    logic       pwm_b;
    logic [7:0] duty_a;
    logic [7:0] duty_b;

    modport source (output valid, output pwm_a, output pwm_b,
                    output duty_a, output duty_b, input ready);
    modport sink   (input valid, input pwm_a, input pwm_b,
                    input duty_a, input duty_b, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bsdp_timebase.sv */
`default_nettype none

module bsdp_timebase
    import bsdp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic adv,
    input  wire cfg_t cfg,
    output tb_t       tb,
    output logic [7:0] period_q
);

    logic [15:0] prescale_count_reg;
    logic [15:0] prescale_count_next;
    logic [7:0]  period_count_reg;

    always_comb
    begin
        tb.wrap             = 1'b0;
        tb.period_next      = period_count_reg;
        prescale_count_next = prescale_count_reg + 16'd1;
        if (prescale_count_reg >= cfg.prescale)
        begin
            prescale_count_next = '0;
            if (period_count_reg >= cfg.period_top)
            begin
                tb.period_next = '0;
                tb.wrap        = 1'b1;
            end
            else
            begin
                tb.period_next = period_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            period_count_reg   <= '0;
        end
        else if (adv)
        begin
            prescale_count_reg <= prescale_count_next;
            period_count_reg   <= tb.period_next;
        end
    end

    assign period_q = period_count_reg;

endmodule

`default_nettype wire

/* hw/rtl/bsdp_chan.sv */
`default_nettype none

module bsdp_chan
    import bsdp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       adv,
    input  wire cfg_t       cfg,
    input  wire logic       rel_up,
    input  wire logic       rel_down,
    input  wire tb_t        tb,
    output logic [7:0]      shadow_q,
    output logic [7:0]      shadow_next,
    output logic            pwm_next
);

    logic [7:0] shadow_reg;
    logic [7:0] active_reg;
    logic [7:0] active_next;
    logic [7:0] after_up;
    logic [8:0] up_sum;
    logic [8:0] down_floor;

    // up first, then down on the raised value
    always_comb
    begin
        up_sum     = {1'b0, shadow_reg} + {1'b0, cfg.duty_step};
        after_up   = shadow_reg;
        if (rel_up && (shadow_reg < cfg.duty_max))
        begin
            after_up = (up_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max : up_sum[7:0];
        end

        down_floor  = {1'b0, cfg.duty_min} + {1'b0, cfg.duty_step};
        shadow_next = after_up;
        if (rel_down && (after_up > cfg.duty_min))
        begin
            shadow_next = ({1'b0, after_up} < down_floor) ? cfg.duty_min
                                                           : after_up - cfg.duty_step;
        end

        active_next = tb.wrap ? shadow_next : active_reg;
        pwm_next    = tb.period_next < active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= DUTY_MIN_RST;
            active_reg <= DUTY_MIN_RST;
        end
        else if (adv)
        begin
            shadow_reg <= shadow_next;
            active_reg <= active_next;
        end
    end

    assign shadow_q = shadow_reg;

endmodule

`default_nettype wire

/* hw/rtl/button_stepped_dual_pwm.sv */
`default_nettype none

// Dual PWM with button-stepped duty. Every request is one clock tick of the
// PWM timebase carrying four button levels, and yields exactly one result:
// both PWM levels and both pending duties after that tick. A request is
// taken every cycle when results are drained; it passes through the input
// register and then the result register, which lets a new request enter
// while a result waits. Configuration writes are always ready and take
// effect for the next request.
module button_stepped_dual_pwm
    import bsdp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    bsdp_cfg_if.sink    cfg,
    bsdp_btn_if.sink    btn,
    bsdp_res_if.source  res
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic [3:0] s1_btn_reg;
    logic [3:0] prev_btn_reg;
    logic [3:0] released;
    logic       s1_adv;
    logic       res_valid_reg;
    logic       pwm_a_reg;
    logic       pwm_b_reg;
    logic [7:0] duty_a_reg;
    logic [7:0] duty_b_reg;
    tb_t        tb;
    logic [7:0] period_q;
    logic [7:0] shadow_a_q;
    logic [7:0] shadow_b_q;
    logic [7:0] shadow_a_next;
    logic [7:0] shadow_b_next;
    logic       pwm_a_next;
    logic       pwm_b_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale   <= PRESCALE_RST;
            cfg_reg.period_top <= PERIOD_TOP_RST;
            cfg_reg.duty_step  <= DUTY_STEP_RST;
            cfg_reg.duty_min   <= DUTY_MIN_RST;
            cfg_reg.duty_max   <= DUTY_MAX_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_PRESCALE:   cfg_reg.prescale   <= cfg.data;
                REG_PERIOD_TOP: cfg_reg.period_top <= cfg.data[7:0];
                REG_DUTY_STEP:  cfg_reg.duty_step  <= cfg.data[7:0];
                REG_DUTY_MIN:   cfg_reg.duty_min   <= cfg.data[7:0];
                REG_DUTY_MAX:   cfg_reg.duty_max   <= cfg.data[7:0];
                default:        ;
            endcase
        end
    end

    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res.ready);
    assign btn.ready = !s1_valid_reg || s1_adv;
    assign released  = prev_btn_reg & ~s1_btn_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (btn.ready)
        begin
            s1_valid_reg <= btn.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (btn.valid && btn.ready)
        begin
            s1_btn_reg <= {btn.btn_b_down, btn.btn_b_up, btn.btn_a_down, btn.btn_a_up};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_btn_reg <= '0;
        end
        else if (s1_adv)
        begin
            prev_btn_reg <= s1_btn_reg;
        end
    end

    bsdp_timebase u_timebase (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (s1_adv),
        .cfg      (cfg_reg),
        .tb       (tb),
        .period_q (period_q)
    );

    bsdp_chan u_chan_a (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s1_adv),
        .cfg         (cfg_reg),
        .rel_up      (released[0]),
        .rel_down    (released[1]),
        .tb          (tb),
        .shadow_q    (shadow_a_q),
        .shadow_next (shadow_a_next),
        .pwm_next    (pwm_a_next)
    );

    bsdp_chan u_chan_b (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s1_adv),
        .cfg         (cfg_reg),
        .rel_up      (released[2]),
        .rel_down    (released[3]),
        .tb          (tb),
        .shadow_q    (shadow_b_q),
        .shadow_next (shadow_b_next),
        .pwm_next    (pwm_b_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            pwm_a_reg  <= pwm_a_next;
            pwm_b_reg  <= pwm_b_next;
            duty_a_reg <= shadow_a_next;
            duty_b_reg <= shadow_b_next;
        end
    end

    assign res.valid  = res_valid_reg;
    assign res.pwm_a  = pwm_a_reg;
    assign res.pwm_b  = pwm_b_reg;
    assign res.duty_a = duty_a_reg;
    assign res.duty_b = duty_b_reg;

    a_adv_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> res_valid_reg)
        else $error("result register not loaded after advance");

    a_duty_tracks_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (duty_a_reg == shadow_a_q) && (duty_b_reg == shadow_b_q))
        else $error("held duty differs from shadow duty");

    a_pwm_tracks_counter: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> (pwm_a_reg == $past(pwm_a_next)) && (period_q == $past(tb.period_next)))
        else $error("pwm result out of step with period counter");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(period_q) && $stable(shadow_a_q) && $stable(shadow_b_q))
        else $error("state moved without an advancing request");

endmodule

`default_nettype wire

/* tb/sv/tb_button_stepped_dual_pwm.sv */
module tb_button_stepped_dual_pwm;
    import bsdp_pkg::*;

    localparam int IDLE_PCT     = 36;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 100;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;

    localparam logic [3:0] BTN_A_UP   = 4'b0001;
    localparam logic [3:0] BTN_A_DOWN = 4'b0010;
    localparam logic [3:0] BTN_B_UP   = 4'b0100;
    localparam logic [3:0] BTN_B_DOWN = 4'b1000;
    localparam logic [3:0] BTN_NONE   = 4'b0000;

    typedef struct packed {
        logic       pwm_a;
        logic       pwm_b;
        logic [7:0] duty_a;
        logic [7:0] duty_b;
    } tick_out_t;

    logic clk = 1'b0;
    logic rst_n;

    bsdp_cfg_if cfg_if();
    bsdp_btn_if btn_if();
    bsdp_res_if res_if();

    button_stepped_dual_pwm u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .btn   (btn_if),
        .res   (res_if)
    );

    always #2 clk = ~clk;

    // register copies
    logic [15:0] r_prescale;
    logic [7:0]  r_top;
    logic [7:0]  r_step;
    logic [7:0]  r_min;
    logic [7:0]  r_max;

    // timebase and duty state
    logic [15:0] tmr_pre;
    logic [7:0]  tmr_per;
    logic [7:0]  pend_a;
    logic [7:0]  pend_b;
    logic [7:0]  live_a;
    logic [7:0]  live_b;
    logic [3:0]  last_lv;

    tick_out_t  expected_ticks[$];
    int         errors       = 0;
    int         stall_cycles = 0;
    bit         send_idle    = 1'b1;
    bit         take_idle    = 1'b1;
    logic [3:0] cur_lv       = BTN_NONE;

    function automatic void reset_model();
        r_prescale = PRESCALE_RST;
        r_top      = PERIOD_TOP_RST;
        r_step     = DUTY_STEP_RST;
        r_min      = DUTY_MIN_RST;
        r_max      = DUTY_MAX_RST;
        tmr_pre    = '0;
        tmr_per    = '0;
        pend_a     = DUTY_MIN_RST;
        pend_b     = DUTY_MIN_RST;
        live_a     = DUTY_MIN_RST;
        live_b     = DUTY_MIN_RST;
        last_lv    = BTN_NONE;
    endfunction

    function automatic logic [7:0] duty_raise(input logic [7:0] d);
        int sum;
        if (d >= r_max)
            return d;
        sum = int'(d) + int'(r_step);
        return (sum > int'(r_max)) ? r_max : 8'(sum);
    endfunction

    function automatic logic [7:0] duty_lower(input logic [7:0] d);
        if (d <= r_min)
            return d;
        if (int'(d) < int'(r_min) + int'(r_step))
            return r_min;
        return d - r_step;
    endfunction

    function automatic tick_out_t predict_tick(input logic [3:0] lv);
        logic [3:0] rel;
        tick_out_t  o;
        rel = last_lv & ~lv;
        // up before down within one channel
        if (rel[0]) pend_a = duty_raise(pend_a);
        if (rel[1]) pend_a = duty_lower(pend_a);
        if (rel[2]) pend_b = duty_raise(pend_b);
        if (rel[3]) pend_b = duty_lower(pend_b);
        last_lv = lv;
        if (tmr_pre >= r_prescale)
        begin
            tmr_pre = '0;
            if (tmr_per >= r_top)
            begin
                tmr_per = '0;
                live_a  = pend_a;
                live_b  = pend_b;
            end
            else
                tmr_per = tmr_per + 8'd1;
        end
        else
            tmr_pre = tmr_pre + 16'd1;
        o.pwm_a  = (tmr_per < live_a);
        o.pwm_b  = (tmr_per < live_b);
        o.duty_a = pend_a;
        o.duty_b = pend_b;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        errors++;
        if (errors <= PRINT_LIMIT)
            $display("ERROR %s: got %0d, expected %0d", what, got, want);
    endtask

    task automatic send_tick(input logic [3:0] lv);
        while (send_idle && $urandom_range(99) < IDLE_PCT)
        begin
            btn_if.valid <= 1'b0;
            @(posedge clk);
        end
        btn_if.valid      <= 1'b1;
        btn_if.btn_a_up   <= lv[0];
        btn_if.btn_a_down <= lv[1];
        btn_if.btn_b_up   <= lv[2];
        btn_if.btn_b_down <= lv[3];
        @(posedge clk);
        while (!btn_if.ready)
            @(posedge clk);
        expected_ticks.push_back(predict_tick(lv));
    endtask

    task automatic wait_drained();
        btn_if.valid <= 1'b0;
        @(posedge clk);
        while (expected_ticks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_PRESCALE:   r_prescale = val;
            REG_PERIOD_TOP: r_top      = val[7:0];
            REG_DUTY_STEP:  r_step     = val[7:0];
            REG_DUTY_MIN:   r_min      = val[7:0];
            REG_DUTY_MAX:   r_max      = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] ps, input logic [7:0] top, step,
                                  lo, hi);
        wait_drained();
        write_reg(REG_PRESCALE, ps);
        // upper data bits are don't-care for the byte registers
        write_reg(REG_PERIOD_TOP, {8'($urandom), top});
        write_reg(REG_DUTY_STEP, {8'($urandom), step});
        write_reg(REG_DUTY_MIN, {8'($urandom), lo});
        write_reg(REG_DUTY_MAX, {8'($urandom), hi});
        if ($urandom_range(99) < 30)
            write_reg(REG_FIRST_UNUSED + 3'($urandom_range(2)), 16'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [3:0] next_levels(input logic [3:0] favor);
        logic [3:0] lv;
        if ($urandom_range(99) < 20)
            return 4'($urandom);
        lv = cur_lv;
        for (int i = 0; i < 4; i++)
            if ($urandom_range(99) < (favor[i] ? 45 : 12))
                lv[i] = ~lv[i];
        return lv;
    endfunction

    task automatic run_random(input int count, input logic [3:0] favor, input bit pause_mid);
        logic [3:0] lv;
        for (int n = 0; n < count; n++)
        begin
            if (pause_mid && n == count / 2)
                wait_drained();
            lv     = next_levels(favor);
            cur_lv = lv;
            send_tick(lv);
        end
    endtask

    task automatic test_default_steps();
        send_tick(BTN_A_UP);
        send_tick(BTN_NONE);
        // every button released together
        send_tick(BTN_A_UP | BTN_A_DOWN | BTN_B_UP | BTN_B_DOWN);
        send_tick(BTN_NONE);
        send_tick(BTN_A_DOWN);
        send_tick(BTN_NONE);
        // already at the minimum
        send_tick(BTN_A_DOWN);
        send_tick(BTN_B_DOWN);
        send_tick(BTN_NONE);
        cur_lv = BTN_NONE;
    endtask

    task automatic test_extreme_limits();
        apply_settings(16'd0, 8'd1, 8'd255, 8'd0, 8'd255);
        send_tick(BTN_A_UP);
        send_tick(BTN_NONE);
        // a at maximum, b still held
        send_tick(BTN_A_UP | BTN_B_UP);
        send_tick(BTN_B_UP);
        send_tick(BTN_NONE);
        send_tick(BTN_A_DOWN | BTN_B_DOWN);
        send_tick(BTN_NONE);
        send_tick(BTN_NONE);
        cur_lv = BTN_NONE;
    endtask

    task automatic test_inverted_limits();
        // min above max, period top zero wraps on every increment
        apply_settings(16'd0, 8'd0, 8'd1, 8'd200, 8'd10);
        send_tick(BTN_A_UP);
        send_tick(BTN_NONE);
        send_tick(BTN_A_DOWN | BTN_B_UP);
        send_tick(BTN_NONE);
        send_tick(BTN_B_DOWN);
        send_tick(BTN_NONE);
        cur_lv = BTN_NONE;
    endtask

    task automatic test_random_settings();
        logic [15:0] ps;
        logic [7:0]  top;
        logic [7:0]  step;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [7:0]  swap;
        int          pick;
        for (int ph = 0; ph < 10; ph++)
        begin
            pick = $urandom_range(99);
            ps   = (pick < 70) ? 16'($urandom_range(3)) :
                   (pick < 92) ? 16'($urandom_range(4, 24)) : 16'($urandom);
            pick = $urandom_range(99);
            top  = (pick < 60) ? 8'($urandom_range(1, 12)) :
                   (pick < 75) ? 8'd0 : (pick < 88) ? 8'd255 : 8'($urandom);
            pick = $urandom_range(99);
            step = (pick < 50) ? 8'($urandom_range(1, 8)) :
                   (pick < 65) ? 8'd255 : (pick < 75) ? 8'd0 : 8'($urandom);
            pick = $urandom_range(99);
            lo   = 8'($urandom);
            hi   = 8'($urandom);
            if (pick < 15)
            begin
                lo = 8'd0;
                hi = 8'd255;
            end
            else if (pick < 85 && lo > hi)
            begin
                swap = lo;
                lo   = hi;
                hi   = swap;
            end
            apply_settings(ps, top, step, lo, hi);
            run_random(100, 4'($urandom), ph == 3);
        end
    endtask

    task automatic test_steady_stream();
        // full 8-bit period with no idling on either side
        apply_settings(16'd0, 8'd255, 8'($urandom_range(1, 16)), 8'd0, 8'd255);
        send_idle = 1'b0;
        take_idle = 1'b0;
        run_random(300, 4'($urandom), 1'b0);
        send_idle = 1'b1;
        take_idle = 1'b1;
    endtask

    task automatic test_slow_timebase();
        apply_settings(16'hFFFF, 8'd255, DUTY_STEP_RST, DUTY_MIN_RST, DUTY_MAX_RST);
        run_random(40, 4'($urandom), 1'b0);
    endtask

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= !(take_idle && $urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        tick_out_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_ticks.size() == 0)
                report_mismatch("result with no request pending", '0, '0);
            else
            begin
                want = expected_ticks.pop_front();
                if (res_if.pwm_a !== want.pwm_a)
                    report_mismatch("pwm_a", 8'(res_if.pwm_a), 8'(want.pwm_a));
                if (res_if.pwm_b !== want.pwm_b)
                    report_mismatch("pwm_b", 8'(res_if.pwm_b), 8'(want.pwm_b));
                if (res_if.duty_a !== want.duty_a)
                    report_mismatch("duty_a", res_if.duty_a, want.duty_a);
                if (res_if.duty_b !== want.duty_b)
                    report_mismatch("duty_b", res_if.duty_b, want.duty_b);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((btn_if.valid && btn_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("button_stepped_dual_pwm: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        btn_if.valid      <= 1'b0;
        btn_if.btn_a_up   <= 1'b0;
        btn_if.btn_a_down <= 1'b0;
        btn_if.btn_b_up   <= 1'b0;
        btn_if.btn_b_down <= 1'b0;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_default_steps();
        test_extreme_limits();
        test_inverted_limits();
        test_random_settings();
        test_steady_stream();
        test_slow_timebase();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("button_stepped_dual_pwm: match");
        else
            $display("button_stepped_dual_pwm: mismatch");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/bsdp_pkg.sv
hw/rtl/bsdp_if.sv
hw/rtl/bsdp_timebase.sv
hw/rtl/bsdp_chan.sv
hw/rtl/button_stepped_dual_pwm.sv
tb/sv/tb_button_stepped_dual_pwm.sv
